/* src/rvd_pkg.sv */
// ----------------------------------------------------------------------------
// rvd_pkg
// Types and constants shared by the RTP video line depacketizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rvd_pkg;

   // Register indexes of the configuration port
   localparam logic [1:0] CSR_V210_MODE     = 2'd0;
   localparam logic [1:0] CSR_LUMA_STRIDE   = 2'd1;
   localparam logic [1:0] CSR_CHROMA_STRIDE = 2'd2;

   localparam logic        V210_MODE_RESET     = 1'b1;
   localparam logic [15:0] LUMA_STRIDE_RESET   = 16'd5120;
   localparam logic [15:0] CHROMA_STRIDE_RESET = 16'd960;

   // 12 bits cover 2*FIELD_LINES-1 for FIELD_LINES up to 2048
   localparam int FRAME_LINE_W = 12;
   localparam int GROUPS_W     = 13;

   // offset/6 == (offset * 43691) >> 18, exact for offsets below 2^17
   localparam logic [15:0] PGROUP_RECIP = 16'd43691;
   localparam int          PGROUP_SHIFT = 18;

   // 12 bytes RTP header + 2 bytes extended sequence number
   localparam logic [16:0] PAYLOAD_BASE   = 17'd14;
   localparam logic [16:0] LINE_HDR_BYTES = 17'd6;

   localparam logic [63:0] EXT_TIME_RESET = 64'h0000_0000_FFFF_FFFF;

   typedef struct packed {
      logic                    valid;
      logic [FRAME_LINE_W-1:0] frame_line;
      logic [14:0]             pixel_offset;
      logic [GROUPS_W-1:0]     groups;
      logic [16:0]             payload_offset;
      logic [15:0]             payload_length;
   } seg_type;

endpackage

`default_nettype wire

/* src/rvd_seg_map.sv */
// ----------------------------------------------------------------------------
// rvd_seg_map
// Maps one line segment header to an interleaved frame line and pixel group.
// ----------------------------------------------------------------------------
`default_nettype none

module rvd_seg_map import rvd_pkg::*; #(
   parameter int FIELD_LINES = 540
) (
   input  wire logic        frame_open,
   input  wire logic [14:0] line,
   input  wire logic [14:0] pixel_offset,
   input  wire logic [16:0] payload_offset,
   input  wire logic [15:0] payload_length,
   output seg_type          seg
);

   localparam logic [14:0] HalfLines = 15'(FIELD_LINES);
   localparam logic [14:0] AllLines  = 15'(2 * FIELD_LINES);

   logic        in_range;
   logic        upper;
   logic [14:0] line_rel;
   logic [14:0] fl_full;
   logic [30:0] recip_prod;

   always_comb begin
      in_range = (line != 15'd0) && (line <= AllLines);
      upper    = line > HalfLines;
      line_rel = upper ? (line - HalfLines) : (line - 15'd1);
      // second field lines go to odd frame lines
      fl_full  = upper ? ((line_rel << 1) - 15'd1) : (line_rel << 1);
      recip_prod = 31'(pixel_offset) * 31'(PGROUP_RECIP);

      seg.valid          = frame_open && in_range;
      seg.frame_line     = seg.valid ? fl_full[FRAME_LINE_W-1:0] : '0;
      seg.pixel_offset   = pixel_offset;
      seg.groups         = GROUPS_W'(recip_prod >> PGROUP_SHIFT);
      seg.payload_offset = payload_offset;
      seg.payload_length = payload_length;
   end

endmodule

`default_nettype wire

/* src/rtp_video_line_depacketizer.sv */
// ----------------------------------------------------------------------------
// rtp_video_line_depacketizer
// Sequence check, frame tracking and line address generation for RTP video.
// ----------------------------------------------------------------------------
// A packet passes the item register, then the single output register, which
// emits one segment result per cycle unless rsp_stall holds it. One packet
// per cycle with one segment when unstalled; two hold off the next packet.
// Reset (synchronous): sequence, frame and loss tracking cleared, timestamp
// extension restarts, configuration returns to v210 / 5120 / 960.
`default_nettype none

module rtp_video_line_depacketizer import rvd_pkg::*; #(
   parameter int FIELD_LINES = 540
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_sequence_number,
   input  wire logic        req_marker_bit,
   input  wire logic [31:0] req_rtp_time,
   input  wire logic        req_has_second_segment,
   input  wire logic [15:0] req_first_length,
   input  wire logic        req_first_field_id,
   input  wire logic [14:0] req_first_line,
   input  wire logic [14:0] req_first_pixel_offset,
   input  wire logic [15:0] req_second_length,
   input  wire logic [14:0] req_second_line,
   input  wire logic [14:0] req_second_pixel_offset,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_segment_valid,
   output logic [10:0]      rsp_frame_line,
   output logic [31:0]      rsp_luma_address,
   output logic [31:0]      rsp_chroma_address,
   output logic [16:0]      rsp_payload_offset,
   output logic [15:0]      rsp_payload_length,
   output logic [15:0]      rsp_lost_packets,
   output logic             rsp_discontinuity,
   output logic             rsp_frame_done,
   output logic [63:0]      rsp_presentation_time,
   output logic             rsp_last,

   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // configuration
   logic        v210_mode_ff;
   logic [15:0] luma_stride_ff;
   logic [15:0] chroma_stride_ff;

   // tracking state
   logic        seq_known_ff,  seq_known_in;
   logic [15:0] exp_seq_ff,    exp_seq_in;
   logic        start_pend_ff, start_pend_in;
   logic        frame_open_ff, frame_open_in;
   logic        loss_seen_ff,  loss_seen_in;
   logic [63:0] ext_time_ff,   ext_time_in;

   // item register
   logic        a_valid_ff, a_valid_in;
   logic        a_idx_ff,   a_idx_in;
   logic        a_two_ff;
   seg_type     a_seg_ff [2];
   logic [15:0] a_lost_ff;
   logic        a_disc_ff;
   logic        a_done_ff;

   // result register
   logic        b_valid_ff, b_valid_in;
   logic        b_seg_valid_ff;
   logic [10:0] b_frame_line_ff;
   logic [31:0] b_luma_ff;
   logic [31:0] b_chroma_ff;
   logic [16:0] b_pay_off_ff;
   logic [15:0] b_pay_len_ff;
   logic [15:0] b_lost_ff;
   logic        b_disc_ff;
   logic        b_done_ff;
   logic [63:0] b_pts_ff;
   logic        b_last_ff;

   logic        accept;
   logic        b_load;
   logic        a_is_last;
   logic        mismatch;
   logic [15:0] lost;
   logic        open_now;
   logic        done;
   logic [31:0] delta;
   logic [16:0] pay_off0;
   logic [16:0] pay_off1;
   seg_type     seg0;
   seg_type     seg1;
   seg_type     cur;
   logic [27:0] luma_prod;
   logic [27:0] chroma_prod;
   logic [31:0] luma_addr;
   logic [31:0] chroma_addr;
   logic [63:0] pts;

   assign b_load    = !b_valid_ff || !rsp_stall;
   assign a_is_last = (a_idx_ff == a_two_ff);
   assign req_stall = a_valid_ff && !(b_load && a_is_last);
   assign accept    = req_valid && !req_stall;

   // --------------------------------------------------------------------
   // per-packet tracking, evaluated on the incoming transaction
   // --------------------------------------------------------------------
   always_comb begin
      mismatch = seq_known_ff && (req_sequence_number != exp_seq_ff);
      lost     = mismatch ? (req_sequence_number - exp_seq_ff) : 16'd0;
      open_now = frame_open_ff || start_pend_ff;
      done     = open_now && req_marker_bit && req_first_field_id;
      delta    = req_rtp_time - ext_time_ff[31:0];
      pay_off0 = req_has_second_segment ? (PAYLOAD_BASE + (LINE_HDR_BYTES << 1))
                                        : (PAYLOAD_BASE + LINE_HDR_BYTES);
      pay_off1 = pay_off0 + 17'(req_first_length);

      seq_known_in  = seq_known_ff;
      exp_seq_in    = exp_seq_ff;
      start_pend_in = start_pend_ff;
      frame_open_in = frame_open_ff;
      loss_seen_in  = loss_seen_ff;
      ext_time_in   = ext_time_ff;
      if (accept) begin
         seq_known_in  = 1'b1;
         exp_seq_in    = req_sequence_number + 16'd1;
         start_pend_in = req_marker_bit && req_first_field_id;
         frame_open_in = open_now && !done;
         loss_seen_in  = loss_seen_ff || mismatch;
         if (done) begin
            ext_time_in = ext_time_ff + 64'(delta);
         end
      end
   end

   rvd_seg_map #(.FIELD_LINES(FIELD_LINES)) u_map0 (
      .frame_open     (open_now),
      .line           (req_first_line),
      .pixel_offset   (req_first_pixel_offset),
      .payload_offset (pay_off0),
      .payload_length (req_first_length),
      .seg            (seg0)
   );

   rvd_seg_map #(.FIELD_LINES(FIELD_LINES)) u_map1 (
      .frame_open     (open_now),
      .line           (req_second_line),
      .pixel_offset   (req_second_pixel_offset),
      .payload_offset (pay_off1),
      .payload_length (req_second_length),
      .seg            (seg1)
   );

   always_comb begin
      a_valid_in = a_valid_ff;
      a_idx_in   = a_idx_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_idx_in   = 1'b0;
      end else if (a_valid_ff && b_load) begin
         if (a_is_last) begin
            a_valid_in = 1'b0;
         end else begin
            a_idx_in = 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------
   // address generation for the current segment
   // --------------------------------------------------------------------
   always_comb begin
      cur         = a_seg_ff[a_idx_ff];
      luma_prod   = 28'(luma_stride_ff) * 28'(cur.frame_line);
      chroma_prod = 28'(chroma_stride_ff) * 28'(cur.frame_line);
      if (!cur.valid) begin
         luma_addr   = '0;
         chroma_addr = '0;
      end else if (v210_mode_ff) begin
         luma_addr   = 32'(luma_prod) + 32'({cur.groups, 4'b0000});
         chroma_addr = '0;
      end else begin
         luma_addr   = 32'(luma_prod) + 32'(cur.pixel_offset);
         chroma_addr = 32'(chroma_prod) + 32'(cur.pixel_offset >> 1);
      end
      // ext_time_ff holds this packet's value until the next one is accepted;
      // x*300 = x*256 + x*32 + x*8 + x*4
      pts = (ext_time_ff << 8) + (ext_time_ff << 5) + (ext_time_ff << 3)
          + (ext_time_ff << 2);
   end

   assign b_valid_in = b_load ? a_valid_ff : b_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v210_mode_ff     <= V210_MODE_RESET;
         luma_stride_ff   <= LUMA_STRIDE_RESET;
         chroma_stride_ff <= CHROMA_STRIDE_RESET;
         seq_known_ff     <= 1'b0;
         exp_seq_ff       <= '0;
         start_pend_ff    <= 1'b0;
         frame_open_ff    <= 1'b0;
         loss_seen_ff     <= 1'b0;
         ext_time_ff      <= EXT_TIME_RESET;
         a_valid_ff       <= 1'b0;
         a_idx_ff         <= 1'b0;
         b_valid_ff       <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_V210_MODE:     v210_mode_ff     <= csr_data[0];
               CSR_LUMA_STRIDE:   luma_stride_ff   <= csr_data;
               CSR_CHROMA_STRIDE: chroma_stride_ff <= csr_data;
               default: ;
            endcase
         end
         seq_known_ff  <= seq_known_in;
         exp_seq_ff    <= exp_seq_in;
         start_pend_ff <= start_pend_in;
         frame_open_ff <= frame_open_in;
         loss_seen_ff  <= loss_seen_in;
         ext_time_ff   <= ext_time_in;
         a_valid_ff    <= a_valid_in;
         a_idx_ff      <= a_idx_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_two_ff    <= req_has_second_segment;
         a_seg_ff[0] <= seg0;
         a_seg_ff[1] <= seg1;
         a_lost_ff   <= lost;
         a_disc_ff   <= loss_seen_ff || mismatch;
         a_done_ff   <= done;
      end
      if (b_load && a_valid_ff) begin
         b_seg_valid_ff  <= cur.valid;
         b_frame_line_ff <= cur.frame_line[10:0];
         b_luma_ff       <= luma_addr;
         b_chroma_ff     <= chroma_addr;
         b_pay_off_ff    <= cur.payload_offset;
         b_pay_len_ff    <= cur.payload_length;
         b_lost_ff       <= a_lost_ff;
         b_disc_ff       <= a_disc_ff;
         b_done_ff       <= a_done_ff && a_is_last;
         b_pts_ff        <= (a_done_ff && a_is_last) ? pts : 64'd0;
         b_last_ff       <= a_is_last;
      end
   end

   assign rsp_valid             = b_valid_ff;
   assign rsp_segment_valid     = b_seg_valid_ff;
   assign rsp_frame_line        = b_frame_line_ff;
   assign rsp_luma_address      = b_luma_ff;
   assign rsp_chroma_address    = b_chroma_ff;
   assign rsp_payload_offset    = b_pay_off_ff;
   assign rsp_payload_length    = b_pay_len_ff;
   assign rsp_lost_packets      = b_lost_ff;
   assign rsp_discontinuity     = b_disc_ff;
   assign rsp_frame_done        = b_done_ff;
   assign rsp_presentation_time = b_pts_ff;
   assign rsp_last              = b_last_ff;

   // --------------------------------------------------------------------
   // assertions
   // --------------------------------------------------------------------
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last)
      else $error("frame_done on a result that is not the last");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_segment_valid |->
         rsp_frame_line == 11'd0 && rsp_luma_address == 32'd0 &&
         rsp_chroma_address == 32'd0)
      else $error("invalid segment carries a nonzero address");

   a_loss_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lost_packets != 16'd0 |-> rsp_discontinuity)
      else $error("lost packets reported without discontinuity");

   a_two_seg_stall: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_two_ff && !a_idx_ff |-> req_stall)
      else $error("new transaction taken while a first segment is pending");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last && !rsp_stall |=> rsp_valid)
      else $error("second segment result did not follow the first");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RTP video line depacketizer. Packets are built
// directed and at random, mostly as well-formed frames with noise mixed in.
// A local model predicts every segment result, and each accepted result
// transaction is checked field by field. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import rvd_pkg::*;

   localparam int FIELD_LINES   = 540;
   localparam int PGROUP_PIXELS = 6;
   localparam int PGROUP_BYTES  = 16;

   typedef struct packed {
      logic [15:0] seq;
      logic        marker;
      logic [31:0] rtp_time;
      logic        two;
      logic [15:0] len0;
      logic        field0;
      logic [14:0] line0;
      logic [14:0] offs0;
      logic [15:0] len1;
      logic [14:0] line1;
      logic [14:0] offs1;
   } packet_type;

   typedef struct packed {
      logic        segment_valid;
      logic [10:0] frame_line;
      logic [31:0] luma;
      logic [31:0] chroma;
      logic [16:0] pay_off;
      logic [15:0] pay_len;
      logic [15:0] lost;
      logic        disc;
      logic        done;
      logic [63:0] pts;
      logic        last;
   } seg_result_type;

   logic        clock;
   logic        reset;

   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_sequence_number;
   logic        req_marker_bit;
   logic [31:0] req_rtp_time;
   logic        req_has_second_segment;
   logic [15:0] req_first_length;
   logic        req_first_field_id;
   logic [14:0] req_first_line;
   logic [14:0] req_first_pixel_offset;
   logic [15:0] req_second_length;
   logic [14:0] req_second_line;
   logic [14:0] req_second_pixel_offset;

   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_segment_valid;
   logic [10:0] rsp_frame_line;
   logic [31:0] rsp_luma_address;
   logic [31:0] rsp_chroma_address;
   logic [16:0] rsp_payload_offset;
   logic [15:0] rsp_payload_length;
   logic [15:0] rsp_lost_packets;
   logic        rsp_discontinuity;
   logic        rsp_frame_done;
   logic [63:0] rsp_presentation_time;
   logic        rsp_last;

   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   rtp_video_line_depacketizer #(
      .FIELD_LINES(FIELD_LINES)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_sequence_number     (req_sequence_number),
      .req_marker_bit          (req_marker_bit),
      .req_rtp_time            (req_rtp_time),
      .req_has_second_segment  (req_has_second_segment),
      .req_first_length        (req_first_length),
      .req_first_field_id      (req_first_field_id),
      .req_first_line          (req_first_line),
      .req_first_pixel_offset  (req_first_pixel_offset),
      .req_second_length       (req_second_length),
      .req_second_line         (req_second_line),
      .req_second_pixel_offset (req_second_pixel_offset),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_segment_valid       (rsp_segment_valid),
      .rsp_frame_line          (rsp_frame_line),
      .rsp_luma_address        (rsp_luma_address),
      .rsp_chroma_address      (rsp_chroma_address),
      .rsp_payload_offset      (rsp_payload_offset),
      .rsp_payload_length      (rsp_payload_length),
      .rsp_lost_packets        (rsp_lost_packets),
      .rsp_discontinuity       (rsp_discontinuity),
      .rsp_frame_done          (rsp_frame_done),
      .rsp_presentation_time   (rsp_presentation_time),
      .rsp_last                (rsp_last),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   // model copy of the configuration and tracking state
   logic        cfg_v210;
   logic [15:0] cfg_luma_stride;
   logic [15:0] cfg_chroma_stride;
   logic        seq_known;
   logic [15:0] seq_next;
   logic        start_armed;
   logic        frame_open;
   logic        loss_seen;
   logic [63:0] ext_time;

   seg_result_type seg_expect_q[$];

   int          errors;
   int          packets_sent;
   int          results_checked;
   int          frames_closed;
   bit          gaps_on;
   int          rx_hold_request;
   logic [15:0] cur_seq;
   logic [31:0] frame_ts;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      #5ms;
      $display("rtp_video_line_depacketizer test failed");
      $finish;
   end

   task automatic reset_model();
      cfg_v210          = V210_MODE_RESET;
      cfg_luma_stride   = LUMA_STRIDE_RESET;
      cfg_chroma_stride = CHROMA_STRIDE_RESET;
      seq_known         = 1'b0;
      seq_next          = '0;
      start_armed       = 1'b0;
      frame_open        = 1'b0;
      loss_seen         = 1'b0;
      ext_time          = EXT_TIME_RESET;
   endtask

   function automatic seg_result_type map_segment(input logic open,
                                                  input logic [14:0] line,
                                                  input logic [14:0] offs,
                                                  input logic [16:0] pay_off,
                                                  input logic [15:0] pay_len);
      seg_result_type r;
      logic [31:0] fl;
      r = '0;
      if (open && line >= 15'd1 && line <= 2 * FIELD_LINES) begin
         // second field lines interleave between the first field lines
         if (line > FIELD_LINES)
            fl = (line - FIELD_LINES) * 2 - 1;
         else
            fl = (line - 1) * 2;
         r.segment_valid = 1'b1;
         r.frame_line    = fl[10:0];
         if (cfg_v210) begin
            r.luma = cfg_luma_stride * fl + (offs / PGROUP_PIXELS) * PGROUP_BYTES;
         end else begin
            r.luma   = cfg_luma_stride * fl + offs;
            r.chroma = cfg_chroma_stride * fl + offs / 2;
         end
      end
      r.pay_off = pay_off;
      r.pay_len = pay_len;
      return r;
   endfunction

   task automatic predict_packet(input packet_type p);
      seg_result_type res [2];
      logic [15:0] lost;
      logic [16:0] data_start;
      logic [31:0] delta;
      logic [63:0] pts;
      logic        done;
      int          n;
      lost = '0;
      pts  = '0;
      done = 1'b0;
      if (seq_known && p.seq != seq_next) begin
         lost      = p.seq - seq_next;
         loss_seen = 1'b1;
      end
      seq_next  = p.seq + 16'd1;
      seq_known = 1'b1;
      if (start_armed)
         frame_open = 1'b1;
      start_armed = p.marker && p.field0;
      n = p.two ? 2 : 1;
      data_start = PAYLOAD_BASE + LINE_HDR_BYTES * 17'(n);
      res[0] = map_segment(frame_open, p.line0, p.offs0, data_start, p.len0);
      res[1] = map_segment(frame_open, p.line1, p.offs1, data_start + p.len0, p.len1);
      if (frame_open && start_armed) begin
         // forward distance modulo 2^32 extends the timestamp
         delta      = p.rtp_time - ext_time[31:0];
         ext_time   = ext_time + {32'd0, delta};
         pts        = ext_time * 64'd300;
         done       = 1'b1;
         frame_open = 1'b0;
      end
      for (int k = 0; k < n; k++) begin
         res[k].lost = lost;
         res[k].disc = loss_seen;
         res[k].done = (k == n - 1) && done;
         res[k].pts  = (k == n - 1 && done) ? pts : 64'd0;
         res[k].last = (k == n - 1);
         seg_expect_q.push_back(res[k]);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      seg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (seg_expect_q.size() == 0) begin
            $error("result transaction with no expectation pending");
            errors++;
         end else begin
            want = seg_expect_q.pop_front();
            results_checked++;
            if (want.done)
               frames_closed++;
            check_field("segment_valid", want.segment_valid, rsp_segment_valid);
            check_field("frame_line", want.frame_line, rsp_frame_line);
            check_field("luma_address", want.luma, rsp_luma_address);
            check_field("chroma_address", want.chroma, rsp_chroma_address);
            check_field("payload_offset", want.pay_off, rsp_payload_offset);
            check_field("payload_length", want.pay_len, rsp_payload_length);
            check_field("lost_packets", want.lost, rsp_lost_packets);
            check_field("discontinuity", want.disc, rsp_discontinuity);
            check_field("frame_done", want.done, rsp_frame_done);
            check_field("presentation_time", want.pts, rsp_presentation_time);
            check_field("last", want.last, rsp_last);
         end
      end
   end

   // result side: random stall per transaction, or a long hold-off on request
   initial begin
      int wait_cycles;
      rsp_stall = 1'b1;
      @(negedge clock);
      forever begin
         if (rx_hold_request > 0) begin
            wait_cycles     = rx_hold_request;
            rx_hold_request = 0;
         end else begin
            wait_cycles = gaps_on ? $urandom_range(10, 0) : 0;
         end
         if (wait_cycles > 0) begin
            rsp_stall = 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_packet(input packet_type p);
      int gap;
      gap = gaps_on ? $urandom_range(10, 0) : 0;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sequence_number     = p.seq;
      req_marker_bit          = p.marker;
      req_rtp_time            = p.rtp_time;
      req_has_second_segment  = p.two;
      req_first_length        = p.len0;
      req_first_field_id      = p.field0;
      req_first_line          = p.line0;
      req_first_pixel_offset  = p.offs0;
      req_second_length       = p.len1;
      req_second_line         = p.line1;
      req_second_pixel_offset = p.offs1;
      req_valid               = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_packet(p);
      packets_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_valid = 1'b0;
      while (seg_expect_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         CSR_V210_MODE:     cfg_v210          = data[0];
         CSR_LUMA_STRIDE:   cfg_luma_stride   = data;
         CSR_CHROMA_STRIDE: cfg_chroma_stride = data;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic v210, input logic [15:0] luma,
                             input logic [15:0] chroma);
      logic [15:0] mode_word;
      wait_idle();
      mode_word    = 16'($urandom);   // upper bits are don't-care
      mode_word[0] = v210;
      write_csr(CSR_V210_MODE, mode_word);
      write_csr(CSR_LUMA_STRIDE, luma);
      write_csr(CSR_CHROMA_STRIDE, chroma);
   endtask

   function automatic packet_type build_packet(
         input logic [15:0] seq, input logic marker, input logic [31:0] ts,
         input logic two, input logic [15:0] len0, input logic field0,
         input logic [14:0] line0, input logic [14:0] offs0, input logic [15:0] len1,
         input logic [14:0] line1, input logic [14:0] offs1);
      packet_type p;
      p.seq      = seq;
      p.marker   = marker;
      p.rtp_time = ts;
      p.two      = two;
      p.len0     = len0;
      p.field0   = field0;
      p.line0    = line0;
      p.offs0    = offs0;
      p.len1     = len1;
      p.line1    = line1;
      p.offs1    = offs1;
      return p;
   endfunction

   function automatic logic [14:0] pick_line(input bit in_range);
      int roll;
      roll = $urandom_range(99, 0);
      if (!in_range || roll < 4)
         return 15'($urandom);
      case ($urandom_range(9, 0))
         0:       return 15'd1;
         1:       return 15'(FIELD_LINES);
         2:       return 15'(FIELD_LINES + 1);
         3:       return 15'(2 * FIELD_LINES);
         default: return 15'($urandom_range(2 * FIELD_LINES, 1));
      endcase
   endfunction

   function automatic logic [14:0] pick_offset();
      if ($urandom_range(1, 0) == 0)
         return 15'($urandom_range(1919, 0));
      return 15'($urandom);
   endfunction

   function automatic packet_type random_packet(input logic [15:0] seq, input logic marker,
                                                input logic field0, input logic [31:0] ts,
                                                input bit in_range);
      return build_packet(seq, marker, ts, 1'($urandom_range(1, 0)), 16'($urandom), field0,
                          pick_line(in_range), pick_offset(), 16'($urandom),
                          pick_line(in_range), pick_offset());
   endfunction

   // mostly in order, with occasional jumps and repeats
   function automatic logic [15:0] next_seq();
      logic [15:0] seq;
      int          roll;
      seq  = cur_seq;
      roll = $urandom_range(99, 0);
      if (roll < 4)
         seq = 16'($urandom);
      else if (roll < 6)
         seq = cur_seq - 16'd1;
      cur_seq = seq + 16'd1;
      return seq;
   endfunction

   // frames of body packets, each closed by a field-one marker that also
   // arms the next frame; a few noise packets carry random marker and lines
   task automatic run_frames(input int n_items);
      packet_type p;
      int      sent;
      int      body;
      sent = 1;
      send_packet(random_packet(next_seq(), 1'b1, 1'b1, frame_ts, 1'b1));
      while (sent < n_items) begin
         body = $urandom_range(6, 1);
         if ($urandom_range(9, 0) == 0)
            frame_ts = $urandom;
         else
            frame_ts = frame_ts + 32'd3003;
         for (int k = 0; k < body; k++) begin
            if ($urandom_range(99, 0) < 8)
               p = random_packet(next_seq(), 1'($urandom_range(1, 0)),
                                 1'($urandom_range(1, 0)), $urandom, 1'b0);
            else
               p = random_packet(next_seq(), 1'b0, 1'($urandom_range(1, 0)), frame_ts, 1'b1);
            send_packet(p);
            sent++;
         end
         send_packet(random_packet(next_seq(), 1'b1, 1'b1, frame_ts, 1'b1));
         sent++;
         if ($urandom_range(24, 0) == 0)
            wait_idle();
      end
   endtask

   task automatic test_frame_tracking();
      // no frame yet, then a field-two marker that must not arm a frame
      send_packet(build_packet(16'd100, 1'b0, 32'd0, 1'b1, 16'h0000, 1'b0, 15'd1, 15'd0,
                               16'hFFFF, 15'h7FFF, 15'h7FFF));
      send_packet(build_packet(16'd101, 1'b1, 32'd1000, 1'b0, 16'd100, 1'b0, 15'd5, 15'd5,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd102, 1'b1, 32'd2000, 1'b0, 16'd200, 1'b1, 15'd1, 15'd6,
                               16'd0, 15'd0, 15'd0));
      // open frame: field boundaries, offset extremes, lines out of range
      send_packet(build_packet(16'd103, 1'b0, 32'd2100, 1'b1, 16'd1200, 1'b0, 15'd1, 15'd0,
                               16'd1200, 15'd540, 15'h7FFF));
      send_packet(build_packet(16'd104, 1'b0, 32'd2200, 1'b1, 16'hFFFF, 1'b1, 15'd541, 15'd5,
                               16'hFFFF, 15'd1080, 15'd6));
      send_packet(build_packet(16'd105, 1'b0, 32'd2300, 1'b1, 16'd10, 1'b0, 15'd0, 15'd0,
                               16'd10, 15'd1081, 15'd1));
      send_packet(build_packet(16'd106, 1'b0, 32'd2400, 1'b0, 16'd10, 1'b0, 15'h7FFF, 15'd100,
                               16'd0, 15'd0, 15'd0));
      // close, which also restarts; then timestamp back-step and forward wrap
      send_packet(build_packet(16'd107, 1'b1, 32'd3003, 1'b1, 16'd500, 1'b1, 15'd2, 15'd12,
                               16'd500, 15'd542, 15'd18));
      send_packet(build_packet(16'd108, 1'b0, 32'd4000, 1'b0, 16'd64, 1'b0, 15'd3, 15'd7,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd109, 1'b1, 32'hFFFF_FFF0, 1'b0, 16'd64, 1'b1, 15'd4, 15'd8,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd110, 1'b0, 32'd5000, 1'b0, 16'd64, 1'b0, 15'd5, 15'd9,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd111, 1'b1, 32'h0000_0010, 1'b1, 16'd32, 1'b1, 15'd6, 15'd10,
                               16'd32, 15'd546, 15'd11));
      wait_idle();
   endtask

   task automatic test_sequence_loss();
      // jump, wrap, duplicate and skip
      send_packet(build_packet(16'd200, 1'b0, 32'd0, 1'b0, 16'd1, 1'b0, 15'd1, 15'd0,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd201, 1'b0, 32'd0, 1'b0, 16'd1, 1'b0, 15'd1, 15'd0,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'hFFFF, 1'b0, 32'd0, 1'b1, 16'd1, 1'b0, 15'd1, 15'd0,
                               16'd2, 15'd2, 15'd0));
      send_packet(build_packet(16'h0000, 1'b0, 32'd0, 1'b0, 16'd1, 1'b0, 15'd1, 15'd0,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'h0000, 1'b0, 32'd0, 1'b0, 16'd1, 1'b0, 15'd1, 15'd0,
                               16'd0, 15'd0, 15'd0));
      send_packet(build_packet(16'd5, 1'b1, 32'd0, 1'b0, 16'd1, 1'b1, 15'd1, 15'd0,
                               16'd0, 15'd0, 15'd0));
      wait_idle();
   endtask

   task automatic test_addressing_extremes();
      set_config(1'b0, 16'hFFFF, 16'hFFFF);
      send_packet(build_packet(16'd6, 1'b0, 32'd100, 1'b1, 16'd4, 1'b0, 15'd1080, 15'h7FFF,
                               16'd4, 15'd1079, 15'd1));
      set_config(1'b0, 16'd0, 16'd0);
      send_packet(build_packet(16'd7, 1'b0, 32'd100, 1'b0, 16'd4, 1'b0, 15'd540, 15'h7FFF,
                               16'd0, 15'd0, 15'd0));
      set_config(1'b1, 16'hFFFF, 16'd0);
      send_packet(build_packet(16'd8, 1'b0, 32'd100, 1'b1, 16'd4, 1'b0, 15'd1080, 15'h7FFF,
                               16'd4, 15'd1, 15'd5));
      send_packet(build_packet(16'd9, 1'b1, 32'd200, 1'b0, 16'd4, 1'b1, 15'd2, 15'd0,
                               16'd0, 15'd0, 15'd0));
      wait_idle();
      cur_seq = 16'd10;
   endtask

   task automatic test_output_holdoff();
      set_config(1'b1, 16'd5120, 16'd960);
      gaps_on         = 1'b0;
      rx_hold_request = 200;
      run_frames(40);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      set_config(1'b1, 16'd5120, 16'd960);
      run_frames(150);
      set_config(1'b0, 16'd3840, 16'd1920);
      run_frames(150);
      set_config(1'b0, 16'($urandom), 16'($urandom));
      run_frames(150);
      set_config(1'b1, 16'hFFFF, 16'hFFFF);
      run_frames(100);
      set_config(1'b0, 16'd0, 16'hFFFF);
      run_frames(100);
      set_config(1'($urandom_range(1, 0)), 16'($urandom), 16'($urandom));
      run_frames(150);
      wait_idle();
   endtask

   task automatic test_no_idle();
      set_config(1'b0, 16'hFFFF, 16'd0);
      gaps_on = 1'b0;
      run_frames(120);
      wait_idle();
      gaps_on = 1'b1;
   endtask

   initial begin
      reset                   = 1'b1;
      req_valid               = 1'b0;
      req_sequence_number     = '0;
      req_marker_bit          = 1'b0;
      req_rtp_time            = '0;
      req_has_second_segment  = 1'b0;
      req_first_length        = '0;
      req_first_field_id      = 1'b0;
      req_first_line          = '0;
      req_first_pixel_offset  = '0;
      req_second_length       = '0;
      req_second_line         = '0;
      req_second_pixel_offset = '0;
      csr_write               = 1'b0;
      csr_index               = CSR_V210_MODE;
      csr_data                = '0;
      errors                  = 0;
      packets_sent            = 0;
      results_checked         = 0;
      frames_closed           = 0;
      gaps_on                 = 1'b1;
      rx_hold_request         = 0;
      cur_seq                 = '0;
      frame_ts                = $urandom;
      reset_model();
      repeat (7) @(negedge clock);
      reset = 1'b0;

      test_frame_tracking();
      test_sequence_loss();
      test_addressing_extremes();
      test_output_holdoff();
      test_random_traffic();
      test_no_idle();

      wait_idle();
      repeat (10) @(negedge clock);
      $display("Covered %0d packets, %0d segment results, %0d closed frames.",
               packets_sent, results_checked, frames_closed);
      $display("Both address modes at stride extremes, sequence gaps, timestamp wrap, hold-off.");
      if (errors == 0)
         $display("rtp_video_line_depacketizer test passed");
      else
         $display("rtp_video_line_depacketizer test failed");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
src/rvd_pkg.sv
src/rvd_seg_map.sv
src/rtp_video_line_depacketizer.sv
tb/tb_top.sv
